[sv/adpcm_pkg.sv]
// ============================================================================
// adpcm_pkg: shared types and constants of the IMA ADPCM codec
// Holds the command codes, result kinds, step table, index adjust table and
// the predictor update structure used by the codec datapath.
// ============================================================================
package adpcm_pkg;

  // Commands carried in the input side-band.
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_DECODE = 2'd2
  } cmd_t;

  // Result kinds carried in the output side-band.
  localparam logic KIND_PCM  = 1'b0;
  localparam logic KIND_CODE = 1'b1;

  // Step index limit and sample limits.
  localparam logic [6:0]         MAX_INDEX = 7'd88;
  localparam logic signed [15:0] PCM_MAX   = 16'sh7FFF;
  localparam logic signed [15:0] PCM_MIN   = 16'sh8000;
  localparam logic signed [17:0] SUM_MAX   = 18'sd32767;
  localparam logic signed [17:0] SUM_MIN   = -18'sd32768;

  // Standard IMA quantizer step sizes, one per step index.
  localparam logic [14:0] STEP_TABLE [0:88] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // Step index movement per magnitude code.
  localparam logic signed [4:0] INDEX_ADJUST [0:7] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

  // New predictor state of one channel after applying one code.
  typedef struct packed {
    logic signed [15:0] pred;
    logic [6:0]         idx;
  } chan_upd_t;

endpackage

[sv/adpcm_quant.sv]
// ============================================================================
// adpcm_quant: IMA ADPCM quantizer
// Turns the difference between an input sample and the prediction into a
// sign bit and three magnitude bits, using the step of the current index.
// ============================================================================
module adpcm_quant (
  input  logic signed [15:0] pcm_i,
  input  logic signed [15:0] pred_i,
  input  logic [6:0]         idx_i,
  output logic [3:0]         code_o
);

  logic [6:0]         idx_c;
  logic signed [16:0] delta;
  logic               neg;
  logic [16:0]        mag;
  logic [16:0]        rem;
  logic [16:0]        stp;
  logic [2:0]         q;

  // Difference and its magnitude.
  assign idx_c = (idx_i > adpcm_pkg::MAX_INDEX) ? adpcm_pkg::MAX_INDEX : idx_i;
  assign delta = {pcm_i[15], pcm_i} - {pred_i[15], pred_i};
  assign neg   = delta[16];
  assign mag   = neg ? 17'(-delta) : 17'(delta);

  // Three successive compare and subtract steps, halving the step each time.
  always_comb begin
    rem = mag;
    stp = {2'b00, adpcm_pkg::STEP_TABLE[idx_c]};
    q   = 3'b000;
    for (int i = 0; i < 3; i++) begin
      if (rem >= stp) begin
        q[2 - i] = 1'b1;
        rem      = rem - stp;
      end
      stp = stp >> 1;
    end
  end

  assign code_o = {neg, q};

endmodule

[sv/adpcm_update.sv]
// ============================================================================
// adpcm_update: IMA ADPCM predictor and step index update
// Rebuilds the prediction from one 4-bit code with 16-bit clamping and moves
// the step index by the adjust table, clamped to the table range.
// ============================================================================
module adpcm_update (
  input  logic signed [15:0]     pred_i,
  input  logic [6:0]             idx_i,
  input  logic [3:0]             code_i,
  output adpcm_pkg::chan_upd_t   upd_o
);

  logic [6:0]         idx_c;
  logic [14:0]        step;
  logic [15:0]        mag;
  logic signed [17:0] sdiff;
  logic signed [17:0] sum;
  logic signed [4:0]  adj;
  logic signed [8:0]  idx_sum;

  assign idx_c = (idx_i > adpcm_pkg::MAX_INDEX) ? adpcm_pkg::MAX_INDEX : idx_i;
  assign step  = adpcm_pkg::STEP_TABLE[idx_c];

  // Reconstructed difference magnitude from the three magnitude bits.
  assign mag = {4'b0000, step[14:3]}
             + (code_i[2] ? {1'b0, step} : 16'd0)
             + (code_i[1] ? {2'b00, step[14:1]} : 16'd0)
             + (code_i[0] ? {3'b000, step[14:2]} : 16'd0);

  assign sdiff = code_i[3] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
  assign sum   = $signed({{2{pred_i[15]}}, pred_i}) + sdiff;

  // Move the step index by the adjust table.
  assign adj     = adpcm_pkg::INDEX_ADJUST[code_i[2:0]];
  assign idx_sum = $signed({2'b00, idx_c}) + $signed({{4{adj[4]}}, adj});

  // Clamp the new prediction to the 16-bit sample range and the step index
  // to the table range.
  always_comb begin
    if (sum > adpcm_pkg::SUM_MAX) begin
      upd_o.pred = adpcm_pkg::PCM_MAX;
    end else if (sum < adpcm_pkg::SUM_MIN) begin
      upd_o.pred = adpcm_pkg::PCM_MIN;
    end else begin
      upd_o.pred = sum[15:0];
    end
    if (idx_sum < 9'sd0) begin
      upd_o.idx = 7'd0;
    end else if (idx_sum > $signed({2'b00, adpcm_pkg::MAX_INDEX})) begin
      upd_o.idx = adpcm_pkg::MAX_INDEX;
    end else begin
      upd_o.idx = idx_sum[6:0];
    end
  end

endmodule

[sv/ima_adpcm_codec.sv]
// ============================================================================
// ima_adpcm_codec: multi-channel 4-bit IMA ADPCM encoder and decoder
// Stream in, stream out; one item register feeding a quantizer and a
// predictor update unit, with per-channel state and an output register.
// ============================================================================
// An item is held in the input register while the codec unit works on it.
// Encode and decode items have two phases: encode quantizes in the first
// phase and updates the channel predictor in the second, decode runs one
// nibble through the predictor update unit per cycle and delivers one
// sample per cycle while the output slot is free. Clear and ignored items
// finish in a single phase. The next item is accepted in the cycle the
// current one finishes; a steady stream of encode or decode items is paced
// by the two phases of each item; each nibble passes once through the single
// predictor update unit. Results sit in an output register, so the unit
// keeps working while a result waits, as long as it has no new one to place.
// ============================================================================
module ima_adpcm_codec #(
  parameter int CHAN_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] pcm_in, [23:16] code_in
  input  logic [3:0]  in_tuser,   // [1:0] command, [2] channel, [3] block_start
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] pcm_out, [23:16] code_out
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);

  localparam int CH_IW = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;

  // Input item register.
  logic               in_valid_r;
  logic               phase_r;
  adpcm_pkg::cmd_t    cmd_r;
  logic               ch_r;
  logic signed [15:0] pcm_r;
  logic [7:0]         byte_r;
  logic               bstart_r;
  logic [3:0]         code_r;

  // Per-channel state.
  logic signed [15:0] pred_r   [CHAN_COUNT];
  logic [6:0]         idx_r    [CHAN_COUNT];
  logic [3:0]         pend_r   [CHAN_COUNT];
  logic               nphase_r [CHAN_COUNT];

  // Output register.
  logic               out_valid_r;
  logic               out_kind_r;
  logic signed [15:0] out_pcm_r;
  logic [7:0]         out_code_r;
  logic               out_last_r;

  // Datapath and control.
  logic                 ch_ok;
  logic [CH_IW-1:0]     ch_idx;
  logic                 is_clr;
  logic                 is_enc;
  logic                 is_dec;
  logic                 eff_nphase;
  logic                 emit;
  logic                 out_free;
  logic                 adv;
  logic                 done;
  logic                 apply;
  logic [3:0]           q_code;
  logic [3:0]           nib;
  adpcm_pkg::chan_upd_t upd;

  // Decode of the held item.
  assign ch_ok      = ({31'd0, ch_r} < 32'(CHAN_COUNT));
  assign ch_idx     = CH_IW'(ch_r);
  assign is_clr     = in_valid_r && (cmd_r == adpcm_pkg::CMD_CLEAR);
  assign is_enc     = in_valid_r && ch_ok && (cmd_r == adpcm_pkg::CMD_ENCODE);
  assign is_dec     = in_valid_r && ch_ok && (cmd_r == adpcm_pkg::CMD_DECODE);
  assign eff_nphase = !bstart_r && nphase_r[ch_idx];

  // A result is placed in the second encode phase of an odd nibble and in
  // both decode phases; the unit waits only when the output slot is taken.
  assign emit     = (is_enc && phase_r && eff_nphase) || is_dec;
  assign out_free = !out_valid_r || out_tready;
  assign adv      = in_valid_r && (!emit || out_free);
  assign done     = adv && (phase_r || !(is_enc || is_dec));
  assign apply    = adv && ((is_enc && phase_r) || is_dec);
  assign nib      = is_enc ? code_r : (phase_r ? byte_r[7:4] : byte_r[3:0]);

  assign in_tready = !in_valid_r || done;

  adpcm_quant u_quant (
    .pcm_i  (pcm_r),
    .pred_i (pred_r[ch_idx]),
    .idx_i  (idx_r[ch_idx]),
    .code_o (q_code)
  );

  adpcm_update u_update (
    .pred_i (pred_r[ch_idx]),
    .idx_i  (idx_r[ch_idx]),
    .code_i (nib),
    .upd_o  (upd)
  );

  // Item control: valid flag and the item phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (done) begin
        phase_r <= 1'b0;
      end else if (adv) begin
        phase_r <= 1'b1;
      end
    end
  end

  // Item payload and the quantized code between the two encode phases.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r    <= adpcm_pkg::cmd_t'(in_tuser[1:0]);
      ch_r     <= in_tuser[2];
      bstart_r <= in_tuser[3];
      pcm_r    <= in_tdata[15:0];
      byte_r   <= in_tdata[23:16];
    end
    if (adv && is_enc && !phase_r) begin
      code_r <= q_code;
    end
  end

  // Channel state: cleared by reset or the clear command, else updated.
  always_ff @(posedge clk) begin
    if (!rst_n || (adv && is_clr)) begin
      for (int c = 0; c < CHAN_COUNT; c++) begin
        pred_r[c]   <= 16'sd0;
        idx_r[c]    <= 7'd0;
        pend_r[c]   <= 4'd0;
        nphase_r[c] <= 1'b0;
      end
    end else if (apply) begin
      pred_r[ch_idx] <= upd.pred;
      idx_r[ch_idx]  <= upd.idx;
      if (is_enc) begin
        if (eff_nphase) begin
          nphase_r[ch_idx] <= 1'b0;
        end else begin
          pend_r[ch_idx]   <= code_r;
          nphase_r[ch_idx] <= 1'b1;
        end
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      if (is_enc) begin
        out_kind_r <= adpcm_pkg::KIND_CODE;
        out_pcm_r  <= 16'sd0;
        out_code_r <= {code_r, pend_r[ch_idx]};
        out_last_r <= 1'b1;
      end else begin
        out_kind_r <= adpcm_pkg::KIND_PCM;
        out_pcm_r  <= upd.pred;
        out_code_r <= 8'd0;
        out_last_r <= phase_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_code_r, out_pcm_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // A packed code byte is always the only result of its item.
  a_code_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == adpcm_pkg::KIND_CODE)) |-> out_tlast)
    else $error("code byte result without last");

  // The second phase of an item only exists while an item is held.
  a_phase_held : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> in_valid_r)
    else $error("item phase set with no item held");

  // The step index of channel 0 never leaves the table range.
  a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    idx_r[0] <= adpcm_pkg::MAX_INDEX)
    else $error("step index beyond table range");

  // After the first decode nibble is applied, the item is still held in its second phase.
  a_dec_pair : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && is_dec && !phase_r) |=> (in_valid_r && phase_r))
    else $error("decode item lost its second nibble");

endmodule

[tb/tb_ima_adpcm_codec.sv]
// ============================================================================
// tb_ima_adpcm_codec: self-checking testbench for the IMA ADPCM codec
// A short table of directed items (reset state, sample and code extremes,
// clamping, nibble pairing, block restarts, the unused command) is followed
// by about 400 random items in four handshake phases. Every result transfer
// is compared field by field with a typed-in result or the two-channel model.
// ============================================================================
module tb_ima_adpcm_codec;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         PHASE_ITEMS = 100;
  localparam int         DRAIN_CYCLES = 8;

  // One result transfer of the codec.
  typedef struct packed {
    logic        kind;
    logic [15:0] pcm;
    logic [7:0]  code;
    logic        last;
  } result_t;

  // One input transfer, with results typed in for hand-checked rows.
  typedef struct packed {
    logic [1:0]  cmd;
    logic        ch;
    logic [15:0] pcm;
    logic [7:0]  code;
    logic        bs;
    logic        typed;
    logic [1:0]  ntyped;
    result_t     r0;
    result_t     r1;
  } codec_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [15:0] pcm_in, [23:16] code_in
  logic [3:0]  in_tuser;   // [1:0] command, [2] channel, [3] block_start
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [15:0] pcm_out, [23:16] code_out
  logic        out_tuser;  // [0] kind
  logic        out_tlast;

  // Channel state of the in-bench codec model.
  logic signed [15:0] chan_pred  [0:1];
  logic [6:0]         chan_idx   [0:1];
  logic [3:0]         chan_nib   [0:1];
  logic               chan_phase [0:1];

  result_t     adpcm_results_q [$];
  codec_item_t directed_items [$];

  int idle_pct;
  int stall_pct;
  int mismatch_count;
  int checked_count;
  int cycle_count;
  int n_encode, n_decode, n_clear, n_ignored;
  int walk_pcm [0:1];

  ima_adpcm_codec DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t mk_result(input logic kind, input logic [15:0] pcm,
                                        input logic [7:0] code, input logic last);
    result_t r;
    r.kind = kind;
    r.pcm  = pcm;
    r.code = code;
    r.last = last;
    return r;
  endfunction

  // Run one nibble through a channel's predictor and step index.
  function automatic logic signed [15:0] advance_predictor(input int ch,
                                                           input logic [3:0] nib);
    int idx, stp, diff, sum, nidx;
    idx = int'(chan_idx[ch]);
    if (idx > int'(adpcm_pkg::MAX_INDEX)) idx = int'(adpcm_pkg::MAX_INDEX);
    stp  = int'(adpcm_pkg::STEP_TABLE[idx]);
    diff = stp >> 3;
    if (nib[2]) diff += stp;
    if (nib[1]) diff += stp >> 1;
    if (nib[0]) diff += stp >> 2;
    if (nib[3]) diff = -diff;
    sum = int'(chan_pred[ch]) + diff;
    if (sum > int'(adpcm_pkg::PCM_MAX)) sum = int'(adpcm_pkg::PCM_MAX);
    if (sum < int'(adpcm_pkg::PCM_MIN)) sum = int'(adpcm_pkg::PCM_MIN);
    chan_pred[ch] = sum[15:0];
    nidx = idx + int'(adpcm_pkg::INDEX_ADJUST[nib[2:0]]);
    if (nidx < 0) nidx = 0;
    else if (nidx > int'(adpcm_pkg::MAX_INDEX)) nidx = int'(adpcm_pkg::MAX_INDEX);
    chan_idx[ch] = nidx[6:0];
    return chan_pred[ch];
  endfunction

  // Apply one command to the model state and work out the results it causes.
  task automatic run_adpcm_command(input codec_item_t it, output int n,
                                   output result_t r0, output result_t r1);
    int ch, idx, stp, sample, delta;
    logic [3:0] code;
    logic [3:0] weight;
    n  = 0;
    r0 = '0;
    r1 = '0;
    ch = int'(it.ch);
    case (it.cmd)
      adpcm_pkg::CMD_CLEAR: begin
        for (int c = 0; c < 2; c++) begin
          chan_pred[c]  = '0;
          chan_idx[c]   = '0;
          chan_nib[c]   = '0;
          chan_phase[c] = 1'b0;
        end
      end
      adpcm_pkg::CMD_ENCODE: begin
        if (it.bs) chan_phase[ch] = 1'b0;
        idx = int'(chan_idx[ch]);
        if (idx > int'(adpcm_pkg::MAX_INDEX)) idx = int'(adpcm_pkg::MAX_INDEX);
        stp    = int'(adpcm_pkg::STEP_TABLE[idx]);
        sample = int'($signed(it.pcm));
        delta  = sample - int'(chan_pred[ch]);
        code   = 4'd0;
        if (delta < 0) begin
          delta = -delta;
          code  = 4'd8;
        end
        // Three magnitude bits, halving the step each time.
        weight = 4'd4;
        for (int i = 0; i < 3; i++) begin
          if (delta >= stp) begin
            code  = code | weight;
            delta = delta - stp;
          end
          stp    = stp >> 1;
          weight = weight >> 1;
        end
        void'(advance_predictor(ch, code));
        if (chan_phase[ch]) begin
          chan_phase[ch] = 1'b0;
          r0 = mk_result(adpcm_pkg::KIND_CODE, 16'd0, {code, chan_nib[ch]}, 1'b1);
          n  = 1;
        end else begin
          chan_nib[ch]   = code;
          chan_phase[ch] = 1'b1;
        end
      end
      adpcm_pkg::CMD_DECODE: begin
        r0 = mk_result(adpcm_pkg::KIND_PCM, advance_predictor(ch, it.code[3:0]), 8'd0,
                       1'b0);
        r1 = mk_result(adpcm_pkg::KIND_PCM, advance_predictor(ch, it.code[7:4]), 8'd0,
                       1'b1);
        n  = 2;
      end
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [1:0] cmd, input logic ch, input logic [15:0] pcm,
                         input logic [7:0] code, input logic bs, input logic typed,
                         input logic [1:0] ntyped, input result_t r0, input result_t r1);
    codec_item_t it;
    it.cmd    = cmd;
    it.ch     = ch;
    it.pcm    = pcm;
    it.code   = code;
    it.bs     = bs;
    it.typed  = typed;
    it.ntyped = ntyped;
    it.r0     = r0;
    it.r1     = r1;
    directed_items.push_back(it);
  endtask

  // Present one item, hold it until the transfer, then queue its results.
  task automatic send_item(input codec_item_t it);
    int n;
    result_t p0, p1;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.code, it.pcm};
    in_tuser  <= {it.bs, it.ch, it.cmd};
    do @(posedge clk); while (!in_tready);
    run_adpcm_command(it, n, p0, p1);
    if (it.typed) begin
      n  = int'(it.ntyped);
      p0 = it.r0;
      p1 = it.r1;
    end
    if (n > 0) adpcm_results_q.push_back(p0);
    if (n > 1) adpcm_results_q.push_back(p1);
    case (it.cmd)
      adpcm_pkg::CMD_CLEAR:  n_clear++;
      adpcm_pkg::CMD_ENCODE: n_encode++;
      adpcm_pkg::CMD_DECODE: n_decode++;
      default:               n_ignored++;
    endcase
    @(negedge clk);
  endtask

  // Stop sending until every queued result has been delivered.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (adpcm_results_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Random item, mostly encode runs and decodes with varied content.
  task automatic make_random_item(output codec_item_t it);
    int sel, ch;
    it       = '0;
    ch       = int'($urandom_range(1));
    it.ch    = 1'(ch);
    it.pcm   = 16'($urandom_range(16'hFFFF));
    it.code  = 8'($urandom_range(8'hFF));
    it.bs    = ($urandom_range(9) == 0);
    sel      = int'($urandom_range(99));
    if (sel < 4) begin
      it.cmd = adpcm_pkg::CMD_CLEAR;
    end else if (sel < 8) begin
      it.cmd = CMD_UNUSED;
    end else if (sel < 52) begin
      it.cmd = adpcm_pkg::CMD_ENCODE;
      sel = int'($urandom_range(9));
      if (sel < 6) begin
        // Slowly moving waveform per channel, like real audio.
        walk_pcm[ch] = walk_pcm[ch] + int'($urandom_range(4000)) - 2000;
        if (walk_pcm[ch] > int'(adpcm_pkg::PCM_MAX)) walk_pcm[ch] = int'(adpcm_pkg::PCM_MAX);
        if (walk_pcm[ch] < int'(adpcm_pkg::PCM_MIN)) walk_pcm[ch] = int'(adpcm_pkg::PCM_MIN);
        it.pcm = walk_pcm[ch][15:0];
      end else if (sel == 8) begin
        it.pcm = $urandom_range(1) ? adpcm_pkg::PCM_MAX : adpcm_pkg::PCM_MIN;
      end else if (sel == 9) begin
        it.pcm = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
    end else begin
      it.cmd = adpcm_pkg::CMD_DECODE;
      case ($urandom_range(11))
        0:       it.code = 8'h77;
        1:       it.code = 8'hFF;
        2:       it.code = 8'h00;
        3:       it.code = 8'h88;
        default: ;
      endcase
    end
  endtask

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each result transfer with the oldest queued expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      checked_count++;
      if (adpcm_results_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none, actual kind %0d data %h last %0d", $time,
                 out_tuser, out_tdata, out_tlast);
      end else begin
        exp_r = adpcm_results_q.pop_front();
        if (out_tuser !== exp_r.kind) begin
          mismatch_count++;
          $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, out_tuser);
        end
        if (out_tdata[15:0] !== exp_r.pcm) begin
          mismatch_count++;
          $display("%0t: pcm_out expected %h actual %h", $time, exp_r.pcm,
                   out_tdata[15:0]);
        end
        if (out_tdata[23:16] !== exp_r.code) begin
          mismatch_count++;
          $display("%0t: code_out expected %h actual %h", $time, exp_r.code,
                   out_tdata[23:16]);
        end
        if (out_tlast !== exp_r.last) begin
          mismatch_count++;
          $display("%0t: last expected %0d actual %0d", $time, exp_r.last, out_tlast);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ima_adpcm_codec: mismatch");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, drain and verdict.
  initial begin
    codec_item_t it;
    int counted;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    mismatch_count = 0;
    checked_count  = 0;
    cycle_count    = 0;
    n_encode       = 0;
    n_decode       = 0;
    n_clear        = 0;
    n_ignored      = 0;
    walk_pcm[0]    = 0;
    walk_pcm[1]    = 0;
    for (int c = 0; c < 2; c++) begin
      chan_pred[c]  = '0;
      chan_idx[c]   = '0;
      chan_nib[c]   = '0;
      chan_phase[c] = 1'b0;
    end

    // Directed table. Typed-in rows are read straight off the algorithm.
    // Decode of zero codes right after reset: the smallest step rounds to 0.
    add_row(adpcm_pkg::CMD_DECODE, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b1, 2'd2,
            mk_result(adpcm_pkg::KIND_PCM, 16'd0, 8'd0, 1'b0),
            mk_result(adpcm_pkg::KIND_PCM, 16'd0, 8'd0, 1'b1));
    // Two silent samples pack into a zero byte.
    add_row(adpcm_pkg::CMD_ENCODE, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b1, 2'd0, '0, '0);
    add_row(adpcm_pkg::CMD_ENCODE, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b1, 2'd1,
            mk_result(adpcm_pkg::KIND_CODE, 16'd0, 8'h00, 1'b1), '0);
    add_row(adpcm_pkg::CMD_CLEAR, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b1, 2'd0, '0, '0);
    // Full-scale positive then full-scale negative sample.
    add_row(adpcm_pkg::CMD_ENCODE, 1'b0, adpcm_pkg::PCM_MAX, 8'h00, 1'b0, 1'b1, 2'd0,
            '0, '0);
    add_row(adpcm_pkg::CMD_ENCODE, 1'b0, adpcm_pkg::PCM_MIN, 8'h00, 1'b0, 1'b1, 2'd1,
            mk_result(adpcm_pkg::KIND_CODE, 16'd0, 8'hF7, 1'b1), '0);
    add_row(adpcm_pkg::CMD_CLEAR, 1'b1, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 2'd0, '0, '0);
    // Negative zero codes leave the sample at zero.
    add_row(adpcm_pkg::CMD_DECODE, 1'b1, 16'hFFFF, 8'h88, 1'b1, 1'b1, 2'd2,
            mk_result(adpcm_pkg::KIND_PCM, 16'd0, 8'd0, 1'b0),
            mk_result(adpcm_pkg::KIND_PCM, 16'd0, 8'd0, 1'b1));
    // The unused command gives nothing.
    add_row(CMD_UNUSED, 1'b0, 16'hA5A5, 8'h5A, 1'b1, 1'b1, 2'd0, '0, '0);
    // Largest codes drive the index to its top and the sample into clamping.
    repeat (6) add_row(adpcm_pkg::CMD_DECODE, 1'b0, 16'h0000, 8'h77, 1'b0, 1'b0, 2'd0,
                       '0, '0);
    repeat (4) add_row(adpcm_pkg::CMD_DECODE, 1'b0, 16'h0000, 8'hFF, 1'b0, 1'b0, 2'd0,
                       '0, '0);
    // A block restart drops a pending nibble.
    add_row(adpcm_pkg::CMD_ENCODE, 1'b1, 16'h1234, 8'h00, 1'b1, 1'b0, 2'd0, '0, '0);
    add_row(adpcm_pkg::CMD_ENCODE, 1'b1, 16'h8000, 8'h00, 1'b1, 1'b0, 2'd0, '0, '0);
    add_row(adpcm_pkg::CMD_ENCODE, 1'b1, 16'h7FFF, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(adpcm_pkg::CMD_DECODE, 1'b1, 16'h0000, 8'h5A, 1'b0, 1'b0, 2'd0, '0, '0);
    // Pairing survives an ignored item and traffic on the other channel.
    add_row(adpcm_pkg::CMD_ENCODE, 1'b0, 16'hFFFF, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(CMD_UNUSED, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(adpcm_pkg::CMD_DECODE, 1'b1, 16'h0000, 8'hC3, 1'b0, 1'b0, 2'd0, '0, '0);
    add_row(adpcm_pkg::CMD_ENCODE, 1'b0, 16'h0001, 8'h00, 1'b0, 1'b0, 2'd0, '0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_items[i]) send_item(directed_items[i]);
    drain_results();

    // Random phases with different sender and receiver idling.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        make_random_item(it);
        send_item(it);
        if (it.cmd != CMD_UNUSED) counted++;
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d encode, %0d decode, %0d clear and %0d ignored items;",
             n_encode, n_decode, n_clear, n_ignored);
    $display("%0d result transfers checked across four handshake phases.", checked_count);
    if (mismatch_count == 0) begin
      $display("ima_adpcm_codec: match");
    end else begin
      $display("ima_adpcm_codec: mismatch");
    end
    $finish;
  end

endmodule
